FILE: rtl/pdd_pkg.sv
// Shared widths, constants and the queued command type for the divergence-distance block.
`default_nettype none
package pdd_pkg;
	localparam int COORD_W = 28;
	localparam int TOL_W   = 27;
	localparam int DIST_W  = 48;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int ROOT_W  = DIFF_W;
	localparam int REM_W   = ROOT_W + 3;
	localparam int APB_W   = 32;
	localparam int ADDR_W  = 3;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);
	localparam logic             REG_TOL   = 1'b0;

	typedef struct packed {
		logic              seg;
		logic [DIFF_W-1:0] dx;
		logic [DIFF_W-1:0] dy;
		logic              last;
		logic              div;
	} cmd_t;
endpackage
`default_nettype wire

FILE: rtl/pdd_if.sv
// Item channels: point pairs in, path results out.
`default_nettype none
interface pdd_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [pdd_pkg::COORD_W-1:0] new_x;
	logic signed [pdd_pkg::COORD_W-1:0] new_y;
	logic signed [pdd_pkg::COORD_W-1:0] old_x;
	logic signed [pdd_pkg::COORD_W-1:0] old_y;
	logic                                last_pair;

	modport source (output valid, new_x, new_y, old_x, old_y, last_pair, input ready);
	modport sink (input valid, new_x, new_y, old_x, old_y, last_pair, output ready);
endinterface

interface pdd_out_if;
	logic                         valid;
	logic                         ready;
	logic                         diverged;
	logic [pdd_pkg::DIST_W-1:0]  distance;

	modport source (output valid, diverged, distance, input ready);
	modport sink (input valid, diverged, distance, output ready);
endinterface
`default_nettype wire

FILE: rtl/pdd_front.sv
// Front end: accept pairs, check tolerance, track previous point and queue segment commands.
`default_nettype none
module pdd_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	pdd_in_if.sink                           pairs,
	input  wire logic [pdd_pkg::TOL_W-1:0]   tolerance,
	input  wire logic                        q_full,
	output logic                             push,
	output pdd_pkg::cmd_t                    push_data
);
	import pdd_pkg::*;

	logic [COORD_W-1:0] prev_x_q;
	logic [COORD_W-1:0] prev_y_q;
	logic               have_prev_q;
	logic               found_q;

	logic [DIFF_W-1:0] ex, ey, sx, sy;
	logic              exceed;
	logic              take;

	function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] d);
		return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
	endfunction

	assign ex = mag(DIFF_W'(pairs.new_x) - DIFF_W'(pairs.old_x));
	assign ey = mag(DIFF_W'(pairs.new_y) - DIFF_W'(pairs.old_y));
	assign sx = mag(DIFF_W'(pairs.new_x) - DIFF_W'($signed(prev_x_q)));
	assign sy = mag(DIFF_W'(pairs.new_y) - DIFF_W'($signed(prev_y_q)));
	assign exceed = (ex > DIFF_W'(tolerance)) || (ey > DIFF_W'(tolerance));

	assign pairs.ready = !q_full;
	assign take = pairs.valid && !q_full;
	assign push = take;

	always_comb begin
		push_data.seg  = !found_q && !exceed && have_prev_q;
		push_data.dx   = sx;
		push_data.dy   = sy;
		push_data.last = pairs.last_pair;
		push_data.div  = found_q || exceed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
		end else if (take) begin
			if (pairs.last_pair) begin
				prev_x_q    <= '0;
				prev_y_q    <= '0;
				have_prev_q <= 1'b0;
				found_q     <= 1'b0;
			end else if (!found_q) begin
				if (exceed) begin
					found_q <= 1'b1;
				end else begin
					prev_x_q    <= pairs.new_x;
					prev_y_q    <= pairs.new_y;
					have_prev_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/pdd_queue.sv
// Short command queue between front and back ends.
`default_nettype none
module pdd_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  pdd_pkg::cmd_t      push_data,
	output logic               full,
	input  wire logic          pop,
	output pdd_pkg::cmd_t      pop_data,
	output logic               not_empty
);
	import pdd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_q];

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= nxt(wr_q);
			end
			if (do_pop) begin
				rd_q <= nxt(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/pdd_back.sv
// Back end: segment length by squares and bit-serial root, saturating sum, result register.
`default_nettype none
module pdd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  pdd_pkg::cmd_t      q_data,
	output logic               pop,
	pdd_out_if.source          result
);
	import pdd_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_ROOT, S_ACC, S_DONE} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [SQ_W-1:0]    sqx_q, sqy_q, rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIST_W-1:0]  dist_q;
	logic               out_valid_q;
	logic               out_div_q;
	logic [DIST_W-1:0]  out_dist_q;

	logic [REM_W-1:0]   rem_next, trial;
	logic [DIST_W:0]    sum;
	logic               load_out;

	assign pop      = (state_q == S_IDLE) && q_valid;
	assign rem_next = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
	assign trial    = REM_W'({root_q, 2'b01});
	assign sum      = {1'b0, dist_q} + (DIST_W + 1)'(root_q);
	assign load_out = (state_q == S_DONE) && cmd_q.last && (!out_valid_q || result.ready);

	assign result.valid    = out_valid_q;
	assign result.diverged = out_div_q;
	assign result.distance = out_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			sqx_q       <= '0;
			sqy_q       <= '0;
			rad_q       <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			cnt_q       <= '0;
			dist_q      <= '0;
			out_valid_q <= 1'b0;
			out_div_q   <= 1'b0;
			out_dist_q  <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_data;
						state_q <= q_data.seg ? S_MUL : S_DONE;
					end
				end
				S_MUL: begin
					sqx_q   <= SQ_W'(cmd_q.dx) * SQ_W'(cmd_q.dx);
					sqy_q   <= SQ_W'(cmd_q.dy) * SQ_W'(cmd_q.dy);
					state_q <= S_SUM;
				end
				S_SUM: begin
					rad_q   <= sqx_q + sqy_q;
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					rad_q <= rad_q << 2;
					if (rem_next >= trial) begin
						rem_q  <= rem_next - trial;
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_next;
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					if (cnt_q == CNT_W'(ROOT_W - 1)) begin
						state_q <= S_ACC;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_ACC: begin
					dist_q  <= sum[DIST_W] ? '1 : sum[DIST_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!cmd_q.last) begin
						state_q <= S_IDLE;
					end else if (load_out) begin
						out_div_q   <= cmd_q.div;
						out_dist_q  <= cmd_q.div ? dist_q : '0;
						dist_q      <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/path_divergence_distance.sv
// Path divergence distance: top level with tolerance register, front end, queue and back end.
// Usage:
//   pairs  : one item per path index, a new-path point with the old-path point at the
//            same index; last_pair marks the final pair of the shorter path.
//   result : one item per path, on the marked pair: diverged and the new-path length
//            up to divergence (zero when no divergence was found).
//   APB    : tolerance register at byte address 0; write only while the block is idle.
// Timing:
//   The front end takes an item whenever the command queue has room.
//   The back end works one command at a time; a pair that adds a segment passes
//   through pop, squaring, add, the one-bit-a-cycle root, accumulate and finish;
//   any other pair goes from pop straight to finish.
//   Sustained throughput is therefore bounded by the root unit.
// Reset:
//   Clears the path state, the queue and the result register; tolerance returns to 655.
// Stall:
//   A waiting result holds in the output register; the back end stops at its
//   final step, the queue fills, and pairs.ready falls once it is full.
`default_nettype none
module path_divergence_distance #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pdd_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [pdd_pkg::APB_W-1:0]    pwdata,
	output logic      [pdd_pkg::APB_W-1:0]    prdata,
	output logic                              pready,
	pdd_in_if.sink                            pairs,
	pdd_out_if.source                         result
);
	import pdd_pkg::*;

	logic [TOL_W-1:0] tol_q;
	logic             push, q_full, q_valid, pop;
	cmd_t             push_data, pop_data;

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_TOL) ? APB_W'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_TOL)) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	pdd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pairs     (pairs),
		.tolerance (tol_q),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	pdd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_valid)
	);

	pdd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (pop_data),
		.pop     (pop),
		.result  (result)
	);
endmodule
`default_nettype wire
